[sv/lpfc_pkg.sv]
// ----------------------------------------------------------------------------
// lpfc_pkg: shared types and constants of the length-prefixed frame checker
// Holds the parse phases, status codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    // bytes in each fixed big-endian field (length, name length, checksum)
    localparam int FIELD_BYTES   = 4;
    localparam int FIELD_CNT_W   = $clog2(FIELD_BYTES);
    // configured lengths and everything derived from an accepted length
    localparam int LEN_W         = 27;
    localparam int CFG_IDX_W     = 1;
    localparam int BYTE_W        = 8;
    localparam int SUM_W         = 16;
    localparam int FIELD_W       = FIELD_BYTES * BYTE_W;
    localparam int USER_W        = 3;

    // adler-32 modulus
    localparam logic [SUM_W-1:0] ADLER_MOD = 16'd65521;

    // register reset values
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 27'd8;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 27'd67108864;

    // register indexes on the config channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FRAME_LEN = 1'b0,
        CFG_MAX_FRAME_LEN = 1'b1
    } cfg_index_t;

    // frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_NAME_LEN = 2'd2,
        ST_LENGTH   = 2'd3
    } status_t;

    // parse phases
    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_NAMELEN = 3'd1,
        PH_BODY    = 3'd2,
        PH_CHECK   = 3'd3,
        PH_LOCKED  = 3'd4
    } phase_t;

endpackage

[sv/length_prefixed_frame_checker_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_core: length-prefixed frame parser and checker
// Parses length, name length, name, payload and adler-32 fields, passes name
// and payload bytes out tagged and closes each frame with a status transfer.
// Path: an input transfer passes the input register, then the result register,
//   to m_tvalid; bytes that produce no result are dropped at the input register.
// Throughput: one byte per cycle while the result register is not held by m_tready low.
// Reset: synchronous active-low aresetn returns to the length field phase and
//   reloads min/max frame length; a length error locks the parser until reset.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpfc_pkg::LEN_W-1:0]            cfg_data,
    // input byte stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lpfc_pkg::BYTE_W-1:0]           s_tdata,  // in_byte
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lpfc_pkg::BYTE_W-1:0]           m_tdata,  // out_byte
    output logic                                  m_tlast,  // frame_end
    output logic [lpfc_pkg::USER_W-1:0]           m_tuser   // status[1:0], is_name
);

    localparam int LEN_W   = lpfc_pkg::LEN_W;
    localparam int SUM_W   = lpfc_pkg::SUM_W;
    localparam int BYTE_W  = lpfc_pkg::BYTE_W;
    localparam int FIELD_W = lpfc_pkg::FIELD_W;
    localparam int SHIFT_W = FIELD_W - BYTE_W;

    // configuration registers
    logic [LEN_W-1:0] min_len_reg;
    logic [LEN_W-1:0] max_len_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    lpfc_pkg::phase_t   phase_reg,      phase_next;
    logic [SHIFT_W-1:0] field_shift_reg, field_shift_next;
    logic [LEN_W-1:0]   body_len_reg,   body_len_next;
    logic [LEN_W-1:0]   name_bytes_reg, name_bytes_next;
    logic [LEN_W-1:0]   byte_count_reg, byte_count_next;
    logic [SUM_W-1:0]   sum_low_reg,    sum_low_next;
    logic [SUM_W-1:0]   sum_high_reg,   sum_high_next;
    logic               name_bad_reg,   name_bad_next;

    // result register
    logic                m_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                is_name_reg,   is_name_next;
    logic                frame_end_reg, frame_end_next;
    lpfc_pkg::status_t   status_reg,    status_next;
    logic                emit;

    // handshake: the input register moves on when the result register frees up
    logic advance;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = frame_end_reg;
    assign m_tuser  = {status_reg, is_name_reg};

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= lpfc_pkg::MIN_LEN_RESET;
            max_len_reg <= lpfc_pkg::MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lpfc_pkg::CFG_MIN_FRAME_LEN: min_len_reg <= cfg_data;
                lpfc_pkg::CFG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // complete field word and field-done flag
    logic [FIELD_W-1:0] field_word;
    logic               field_done;
    assign field_word = {field_shift_reg, in_byte_reg};
    assign field_done = (byte_count_reg ==
                         LEN_W'(lpfc_pkg::FIELD_BYTES - 1));

    // adler-32 update of the current byte
    logic [SUM_W:0]   low_sum;
    logic [SUM_W-1:0] low_mod;
    logic [SUM_W:0]   high_sum;
    logic [SUM_W-1:0] high_mod;
    always_comb begin
        low_sum = {1'b0, sum_low_reg} + {{(SUM_W + 1 - BYTE_W){1'b0}}, in_byte_reg};
        if (low_sum >= {1'b0, lpfc_pkg::ADLER_MOD}) begin
            low_mod = SUM_W'(low_sum - {1'b0, lpfc_pkg::ADLER_MOD});
        end else begin
            low_mod = low_sum[SUM_W-1:0];
        end
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_mod};
        if (high_sum >= {1'b0, lpfc_pkg::ADLER_MOD}) begin
            high_mod = SUM_W'(high_sum - {1'b0, lpfc_pkg::ADLER_MOD});
        end else begin
            high_mod = high_sum[SUM_W-1:0];
        end
    end

    // length and name length checks
    logic               len_bad;
    logic               name_field_bad;
    logic [LEN_W-1:0]   body_of_len;
    logic [FIELD_W-1:0] body_wide;
    assign body_wide      = FIELD_W'(body_len_reg);
    assign len_bad        = field_word[FIELD_W-1]
                          || (field_word < FIELD_W'(min_len_reg))
                          || (field_word > FIELD_W'(max_len_reg))
                          || (field_word < FIELD_W'(2 * lpfc_pkg::FIELD_BYTES));
    assign body_of_len    = LEN_W'(field_word[LEN_W-1:0]
                          - LEN_W'(2 * lpfc_pkg::FIELD_BYTES));
    assign name_field_bad = field_word[FIELD_W-1]
                          || (field_word == '0)
                          || (field_word > body_wide);

    // parser next state and result
    always_comb begin
        phase_next       = phase_reg;
        field_shift_next = field_shift_reg;
        body_len_next    = body_len_reg;
        name_bytes_next  = name_bytes_reg;
        byte_count_next  = byte_count_reg;
        sum_low_next     = sum_low_reg;
        sum_high_next    = sum_high_reg;
        name_bad_next    = name_bad_reg;
        emit             = 1'b0;
        out_byte_next    = '0;
        is_name_next     = 1'b0;
        frame_end_next   = 1'b0;
        status_next      = lpfc_pkg::ST_OK;

        case (phase_reg)
            lpfc_pkg::PH_LEN: begin
                field_shift_next = field_word[SHIFT_W-1:0];
                byte_count_next  = byte_count_reg + 1'b1;
                if (field_done) begin
                    byte_count_next = '0;
                    if (len_bad) begin
                        phase_next     = lpfc_pkg::PH_LOCKED;
                        emit           = 1'b1;
                        frame_end_next = 1'b1;
                        status_next    = lpfc_pkg::ST_LENGTH;
                    end else begin
                        body_len_next = body_of_len;
                        sum_low_next  = SUM_W'(1);
                        sum_high_next = '0;
                        name_bad_next = 1'b0;
                        phase_next    = lpfc_pkg::PH_NAMELEN;
                    end
                end
            end
            lpfc_pkg::PH_NAMELEN: begin
                sum_low_next     = low_mod;
                sum_high_next    = high_mod;
                field_shift_next = field_word[SHIFT_W-1:0];
                byte_count_next  = byte_count_reg + 1'b1;
                if (field_done) begin
                    byte_count_next = '0;
                    name_bad_next   = name_field_bad;
                    name_bytes_next = name_field_bad ? '0 : field_word[LEN_W-1:0];
                    phase_next      = (body_len_reg != '0) ? lpfc_pkg::PH_BODY
                                                           : lpfc_pkg::PH_CHECK;
                end
            end
            lpfc_pkg::PH_BODY: begin
                sum_low_next    = low_mod;
                sum_high_next   = high_mod;
                byte_count_next = byte_count_reg + 1'b1;
                if (byte_count_next == body_len_reg) begin
                    byte_count_next = '0;
                    phase_next      = lpfc_pkg::PH_CHECK;
                end
                emit          = 1'b1;
                out_byte_next = in_byte_reg;
                is_name_next  = (byte_count_reg < name_bytes_reg);
            end
            lpfc_pkg::PH_CHECK: begin
                field_shift_next = field_word[SHIFT_W-1:0];
                byte_count_next  = byte_count_reg + 1'b1;
                if (field_done) begin
                    byte_count_next = '0;
                    phase_next      = lpfc_pkg::PH_LEN;
                    emit            = 1'b1;
                    frame_end_next  = 1'b1;
                    if (field_word != {sum_high_reg, sum_low_reg}) begin
                        status_next = lpfc_pkg::ST_CHECKSUM;
                    end else if (name_bad_reg) begin
                        status_next = lpfc_pkg::ST_NAME_LEN;
                    end else begin
                        status_next = lpfc_pkg::ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    // parser control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= lpfc_pkg::PH_LEN;
            byte_count_reg <= '0;
            sum_low_reg    <= SUM_W'(1);
            sum_high_reg   <= '0;
            name_bad_reg   <= 1'b0;
            name_bytes_reg <= '0;
            body_len_reg   <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            sum_low_reg    <= sum_low_next;
            sum_high_reg   <= sum_high_next;
            name_bad_reg   <= name_bad_next;
            name_bytes_reg <= name_bytes_next;
            body_len_reg   <= body_len_next;
        end
    end

    // field shift register, fully refilled by every field
    always_ff @(posedge aclk) begin
        if (advance) begin
            field_shift_reg <= field_shift_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_byte_reg  <= out_byte_next;
            is_name_reg   <= is_name_next;
            frame_end_reg <= frame_end_next;
            status_reg    <= status_next;
        end
    end

endmodule
